// File: design/grs_pkg.sv
// Package for the gravity ray Euler step unit: payload structs, register codes,
// state types, widths and the saturation helpers used by the Euler stage.
// Depends on nothing.
`timescale 1ns / 1ps

package grs_pkg;

	localparam int DATA_W          = 32;
	localparam int ACC_W           = 35;
	localparam int HOLE_W          = 64;
	localparam int NUM_HOLE_REGS   = 4;
	localparam int COUNT_W         = 3;
	localparam int DT_W            = 20;
	localparam int DT_SHIFT        = 20;
	localparam int COEF_W          = 15;
	localparam int RADIUS_W        = 16;
	localparam int CENTER_W        = 16;
	localparam int CENTER_FRAC     = 8;
	localparam int COEF_FRAC       = 24;
	localparam int RANGE_BITS      = 7;
	localparam int RECIP_SHIFT     = 30;
	localparam int QUOT_W          = 61;
	localparam int RESCALE_PASSES  = 4;
	localparam int CFG_ADDR_W      = 6;
	localparam int CFG_DATA_W      = 64;
	localparam int DEF_MAX_HOLES   = 4;
	localparam int DEF_FRAC_BITS   = 20;

	localparam logic [DT_W-1:0]        TIME_STEP_RESET = 20'd10486;
	localparam logic [COEF_W-1:0]      COEF_Q16        = 15'd19661;
	localparam logic signed [ACC_W-1:0] SAT_MAX        = 35'sh0_7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] SAT_MIN        = 35'sh7_8000_0000;

	typedef enum logic [2:0] {
		REG_HOLE_A     = 3'd0,
		REG_HOLE_B     = 3'd1,
		REG_HOLE_C     = 3'd2,
		REG_HOLE_D     = 3'd3,
		REG_HOLE_COUNT = 3'd4,
		REG_TIME_STEP  = 3'd5
	} grs_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_z;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] vel_z;
	} grs_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] new_pos_x;
		logic signed [DATA_W-1:0] new_pos_y;
		logic signed [DATA_W-1:0] new_pos_z;
		logic signed [DATA_W-1:0] new_vel_x;
		logic signed [DATA_W-1:0] new_vel_y;
		logic signed [DATA_W-1:0] new_vel_z;
		logic signed [DATA_W-1:0] accel_x;
		logic signed [DATA_W-1:0] accel_y;
		logic signed [DATA_W-1:0] accel_z;
		logic                     saturated;
	} grs_out_t;

	typedef struct packed {
		logic [2:0][DATA_W-1:0] pos;
		logic [2:0][DATA_W-1:0] vel;
		logic [2:0][ACC_W-1:0]  acc;
		logic                   flag;
	} grs_ray_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_LOAD,
		CS_SQUARE,
		CS_ROOT,
		CS_AXIS,
		CS_RECIP,
		CS_SCALE,
		CS_RESCALE_GO,
		CS_RESCALE,
		CS_ACCUM,
		CS_SEND
	} grs_cell_state_t;

	typedef enum logic [2:0] {
		ES_IDLE,
		ES_CLAMP,
		ES_VEL_MUL,
		ES_VEL_ADD,
		ES_POS_MUL,
		ES_POS_ADD,
		ES_HOLD
	} grs_euler_state_t;

	function automatic logic sat_hit(input logic signed [ACC_W-1:0] v);
		return (v > SAT_MAX) || (v < SAT_MIN);
	endfunction

	function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = v;
		if (v > SAT_MAX) begin
			c = SAT_MAX;
		end else if (v < SAT_MIN) begin
			c = SAT_MIN;
		end
		return c[DATA_W-1:0];
	endfunction

endpackage

// File: design/gravity_ray_euler_step_unit.sv
// Top level of the gravity ray Euler step unit: configuration registers, the
// chain of hole cells and the Euler update stage. Depends on grs_pkg,
// grs_cell and grs_euler.
//
// Use: program the hole words, hole_count and time_step over the APB-style
// port while the unit is idle (byte address 8 times the register index, pready
// always high). Ray samples enter on the sample channel and one result per
// sample leaves on the result channel, both valid/ready; a transaction moves
// on a clock edge where valid and ready are both high.
// Each sample passes through MAX_HOLES cells in order. A cell whose hole is
// not in use passes the sample on unchanged. An active cell computes the pull
// with its bit-serial divider, doing up to five divisions per nonzero axis.
// The cells form a pipeline: each cell holds one sample and takes a new one
// only after handing the last one on. When the receiver stalls, the result
// waits in the output register and the chain fills behind it until
// sample_ready drops. Reset clears all control state and loads the register
// reset values.
`timescale 1ns / 1ps

module gravity_ray_euler_step_unit import grs_pkg::*; #(
	parameter int MAX_HOLES = DEF_MAX_HOLES,
	parameter int FRAC_BITS = DEF_FRAC_BITS
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  grs_in_t               sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output grs_out_t              result
);

	logic [HOLE_W-1:0]  hole_q [NUM_HOLE_REGS];
	logic [COUNT_W-1:0] hole_count_q;
	logic [DT_W-1:0]    time_step_q;
	grs_reg_t           reg_idx;
	logic               wr_en;

	grs_ray_t link_ray   [MAX_HOLES+1];
	logic     link_valid [MAX_HOLES+1];
	logic     link_ready [MAX_HOLES+1];

	assign reg_idx = grs_reg_t'(paddr[CFG_ADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HOLE_REGS; i++) begin
				hole_q[i] <= '0;
			end
			hole_count_q <= '0;
			time_step_q  <= TIME_STEP_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HOLE_A:     hole_q[0]    <= pwdata;
				REG_HOLE_B:     hole_q[1]    <= pwdata;
				REG_HOLE_C:     hole_q[2]    <= pwdata;
				REG_HOLE_D:     hole_q[3]    <= pwdata;
				REG_HOLE_COUNT: hole_count_q <= pwdata[COUNT_W-1:0];
				REG_TIME_STEP:  time_step_q  <= pwdata[DT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HOLE_A:     prdata = hole_q[0];
			REG_HOLE_B:     prdata = hole_q[1];
			REG_HOLE_C:     prdata = hole_q[2];
			REG_HOLE_D:     prdata = hole_q[3];
			REG_HOLE_COUNT: prdata = CFG_DATA_W'(hole_count_q);
			REG_TIME_STEP:  prdata = CFG_DATA_W'(time_step_q);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		link_ray[0].pos[0] = sample.pos_x;
		link_ray[0].pos[1] = sample.pos_y;
		link_ray[0].pos[2] = sample.pos_z;
		link_ray[0].vel[0] = sample.vel_x;
		link_ray[0].vel[1] = sample.vel_y;
		link_ray[0].vel[2] = sample.vel_z;
		link_ray[0].acc    = '0;
		link_ray[0].flag   = 1'b0;
	end

	assign link_valid[0] = sample_valid;
	assign sample_ready  = link_ready[0];

	for (genvar g = 0; g < MAX_HOLES; g++) begin : g_cell
		grs_cell #(
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.hole     (hole_q[g]),
			.active   (COUNT_W'(g) < hole_count_q),
			.up_valid (link_valid[g]),
			.up_ready (link_ready[g]),
			.up_ray   (link_ray[g]),
			.dn_valid (link_valid[g+1]),
			.dn_ready (link_ready[g+1]),
			.dn_ray   (link_ray[g+1])
		);
	end

	grs_euler u_euler (
		.clk          (clk),
		.arst_n       (arst_n),
		.time_step    (time_step_q),
		.up_valid     (link_valid[MAX_HOLES]),
		.up_ready     (link_ready[MAX_HOLES]),
		.up_ray       (link_ray[MAX_HOLES]),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: design/grs_div.sv
// Bit-serial restoring divider used by each hole cell: one quotient bit per cycle.
// Flags overflow up front when the quotient would not fit. Depends on grs_pkg.
`timescale 1ns / 1ps

module grs_div import grs_pkg::*; #(
	parameter int NW = QUOT_W + DEF_FRAC_BITS,
	parameter int DW = DEF_FRAC_BITS + RANGE_BITS + 1
)(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic          ovf,
	output logic [QUOT_W-1:0] quot
);

	localparam int CW = $clog2(QUOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic              ovf_q;
	logic [CW-1:0]     cnt_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     den_q;
	logic [QUOT_W-1:0] low_q;
	logic [DW-1:0]     hi;
	logic [DW:0]       trial;
	logic              fits;

	assign hi    = DW'(num[NW-1:QUOT_W]);
	assign trial = {rem_q, low_q[QUOT_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (hi >= den) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					ovf_q  <= 1'b0;
					busy_q <= 1'b1;
					cnt_q  <= CW'(QUOT_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi;
			den_q <= den;
			low_q <= num[QUOT_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			low_q <= {low_q[QUOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quot = low_q;

endmodule

// File: design/grs_cell.sv
// One hole cell of the chain: adds the gravity term of its black hole to the
// passing ray sample, using one square root sequence for all three axes and a divider.
// Depends on grs_pkg and grs_div.
`timescale 1ns / 1ps

module grs_cell import grs_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [HOLE_W-1:0] hole,
	input  logic              active,
	input  logic              up_valid,
	output logic              up_ready,
	input  grs_ray_t          up_ray,
	output logic              dn_valid,
	input  logic              dn_ready,
	output grs_ray_t          dn_ray
);

	localparam int MW   = FRAC_BITS + RANGE_BITS;
	localparam int SW   = 2 * MW + 2;
	localparam int DW   = MW + 1;
	localparam int RW   = DW + 2;
	localparam int NW   = QUOT_W + FRAC_BITS;
	localparam int KW   = RADIUS_W + COEF_W;
	localparam int UW   = RECIP_SHIFT + 1;
	localparam int PW   = DATA_W + 2;
	localparam int CSH  = FRAC_BITS - CENTER_FRAC;
	localparam int XSH  = COEF_FRAC - FRAC_BITS;
	localparam int CW   = $clog2(DW + 1);
	localparam int MAGW = QUOT_W - RECIP_SHIFT;

	grs_cell_state_t state_q, state_d;

	grs_ray_t         ray_q;
	logic [2:0][MW-1:0] m_q;
	logic [2:0]       neg_q;
	logic [1:0]       ax_q;
	logic [SW-1:0]    s_q;
	logic [RW-1:0]    rem_q;
	logic [DW-1:0]    root_q;
	logic [CW-1:0]    cnt_q;
	logic [KW-1:0]    k_q;
	logic [UW-1:0]    u_q;
	logic [QUOT_W-1:0] x_q;
	logic [1:0]       pass_q;
	logic             ovf_q;

	logic signed [PW-1:0] cext [3];
	logic signed [PW-1:0] pdiff [3];
	logic [PW-1:0]    pmag [3];
	logic             far_any;
	logic             zero_all;
	logic [2*MW-1:0]  sq;
	logic [RW-1:0]    rem_n;
	logic [RW-1:0]    trial;
	logic             root_fit;
	logic [KW+UW-1:0] kxu;
	logic [MAGW-1:0]  mag;
	logic signed [ACC_W-1:0] magext;
	logic signed [ACC_W-1:0] term;

	logic             div_start;
	logic [NW-1:0]    div_num;
	logic             div_done;
	logic             div_ovf;
	logic [QUOT_W-1:0] div_quot;

	grs_div #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (root_q),
		.done   (div_done),
		.ovf    (div_ovf),
		.quot   (div_quot)
	);

	always_comb begin
		far_any  = 1'b0;
		zero_all = 1'b1;
		for (int i = 0; i < 3; i++) begin
			cext[i]  = PW'($signed(hole[CENTER_W*i +: CENTER_W])) <<< CSH;
			pdiff[i] = PW'($signed(ray_q.pos[i])) - cext[i];
			pmag[i]  = pdiff[i][PW-1] ? PW'(-pdiff[i]) : PW'(pdiff[i]);
			far_any  = far_any | (|pmag[i][PW-1:MW]);
			zero_all = zero_all & (pmag[i] == '0);
		end
	end

	assign sq       = m_q[ax_q] * m_q[ax_q];
	assign rem_n    = {rem_q[RW-3:0], s_q[SW-1:SW-2]};
	assign trial    = {root_q, 2'b01};
	assign root_fit = rem_n >= trial;
	assign kxu      = k_q * u_q;
	assign mag      = x_q[QUOT_W-1:RECIP_SHIFT];
	assign magext   = $signed(ACC_W'(mag));

	always_comb begin
		if (ovf_q) begin
			term = neg_q[ax_q] ? SAT_MAX : SAT_MIN;
		end else begin
			term = neg_q[ax_q] ? magext : -magext;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (up_valid) begin
					state_d = active ? CS_LOAD : CS_SEND;
				end
			end
			CS_LOAD: begin
				if (far_any || zero_all) begin
					state_d = CS_SEND;
				end else begin
					state_d = CS_SQUARE;
				end
			end
			CS_SQUARE: begin
				if (ax_q == 2'd2) begin
					state_d = CS_ROOT;
				end
			end
			CS_ROOT: begin
				if (cnt_q == CW'(1)) begin
					state_d = CS_AXIS;
				end
			end
			CS_AXIS: begin
				if (m_q[ax_q] != '0) begin
					state_d = CS_RECIP;
				end else if (ax_q == 2'd2) begin
					state_d = CS_SEND;
				end
			end
			CS_RECIP: begin
				if (div_done) begin
					state_d = CS_SCALE;
				end
			end
			CS_SCALE: begin
				state_d = CS_RESCALE_GO;
			end
			CS_RESCALE_GO: begin
				state_d = CS_RESCALE;
			end
			CS_RESCALE: begin
				if (div_done) begin
					if (div_ovf || pass_q == 2'(RESCALE_PASSES - 1)) begin
						state_d = CS_ACCUM;
					end else begin
						state_d = CS_RESCALE_GO;
					end
				end
			end
			CS_ACCUM: begin
				state_d = (ax_q == 2'd2) ? CS_SEND : CS_AXIS;
			end
			CS_SEND: begin
				if (dn_ready) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		up_ready  = (state_q == CS_IDLE);
		dn_valid  = (state_q == CS_SEND);
		div_start = 1'b0;
		div_num   = {x_q, {FRAC_BITS{1'b0}}};
		unique case (state_q)
			CS_AXIS: begin
				div_start = (m_q[ax_q] != '0);
				div_num   = NW'(m_q[ax_q]) << RECIP_SHIFT;
			end
			CS_RESCALE_GO: begin
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign dn_ray = ray_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_IDLE: begin
				if (up_valid) begin
					ray_q <= up_ray;
				end
			end
			CS_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= pmag[i][MW-1:0];
					neg_q[i] <= pdiff[i][PW-1];
				end
				if (!far_any && zero_all) begin
					ray_q.flag <= 1'b1;
				end
				k_q    <= KW'(hole[HOLE_W-1 -: RADIUS_W]) * KW'(COEF_Q16);
				s_q    <= '0;
				rem_q  <= '0;
				root_q <= '0;
				ax_q   <= 2'd0;
				cnt_q  <= CW'(DW);
			end
			CS_SQUARE: begin
				s_q  <= s_q + SW'(sq);
				ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
			end
			CS_ROOT: begin
				rem_q  <= root_fit ? rem_n - trial : rem_n;
				root_q <= {root_q[DW-2:0], root_fit};
				s_q    <= s_q << 2;
				cnt_q  <= cnt_q - 1'b1;
			end
			CS_AXIS: begin
				ovf_q <= 1'b0;
				if (m_q[ax_q] == '0 && ax_q != 2'd2) begin
					ax_q <= ax_q + 2'd1;
				end
			end
			CS_RECIP: begin
				if (div_done) begin
					u_q <= div_quot[UW-1:0];
				end
			end
			CS_SCALE: begin
				x_q    <= QUOT_W'(kxu >> XSH);
				pass_q <= 2'd0;
			end
			CS_RESCALE: begin
				if (div_done) begin
					if (div_ovf) begin
						ovf_q <= 1'b1;
					end else begin
						x_q    <= div_quot;
						pass_q <= pass_q + 2'd1;
					end
				end
			end
			CS_ACCUM: begin
				ray_q.acc[ax_q] <= ray_q.acc[ax_q] + term;
				if (ovf_q) begin
					ray_q.flag <= 1'b1;
				end
				if (ax_q != 2'd2) begin
					ax_q <= ax_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/grs_euler.sv
// Euler update stage at the end of the chain: clamps the acceleration, then
// steps velocity and position one axis at a time with one shared multiplier.
// Holds the finished result in an output register. Depends on grs_pkg.
`timescale 1ns / 1ps

module grs_euler import grs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [DT_W-1:0] time_step,
	input  logic            up_valid,
	output logic            up_ready,
	input  grs_ray_t        up_ray,
	output logic            result_valid,
	input  logic            result_ready,
	output grs_out_t        result
);

	localparam int PRODW = DATA_W + DT_W;

	grs_euler_state_t state_q, state_d;

	grs_ray_t               ray_q;
	logic [2:0][DATA_W-1:0] accc_q;
	logic [2:0][DATA_W-1:0] vel_q;
	logic [2:0][DATA_W-1:0] pos_q;
	logic [1:0]             ax_q;
	logic [PRODW-1:0]       prod_q;
	logic                   neg_q;
	logic                   flag_q;
	grs_out_t               out_q;
	logic                   out_valid_q;

	logic [DATA_W-1:0]       mul_src;
	logic [DATA_W-1:0]       mul_mag;
	logic [DATA_W-1:0]       step_mag;
	logic signed [ACC_W-1:0] step_val;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] sum;
	logic                    load_out;

	assign mul_src  = (state_q == ES_VEL_MUL) ? accc_q[ax_q] : vel_q[ax_q];
	assign mul_mag  = mul_src[DATA_W-1] ? -mul_src : mul_src;
	assign step_mag = prod_q[PRODW-1:DT_SHIFT] & {DATA_W{1'b1}};
	assign step_val = neg_q ? -$signed(ACC_W'(step_mag)) : $signed(ACC_W'(step_mag));
	assign base     = (state_q == ES_VEL_ADD) ? ACC_W'($signed(vel_q[ax_q]))
	                                          : ACC_W'($signed(pos_q[ax_q]));
	assign sum      = base + step_val;
	assign load_out = (state_q == ES_HOLD) && (!out_valid_q || result_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ES_IDLE: begin
				if (up_valid) begin
					state_d = ES_CLAMP;
				end
			end
			ES_CLAMP:   state_d = ES_VEL_MUL;
			ES_VEL_MUL: state_d = ES_VEL_ADD;
			ES_VEL_ADD: state_d = ES_POS_MUL;
			ES_POS_MUL: state_d = ES_POS_ADD;
			ES_POS_ADD: state_d = (ax_q == 2'd2) ? ES_HOLD : ES_VEL_MUL;
			ES_HOLD: begin
				if (load_out) begin
					state_d = ES_IDLE;
				end
			end
			default:    state_d = ES_IDLE;
		endcase
	end

	always_comb begin
		up_ready     = (state_q == ES_IDLE);
		result_valid = out_valid_q;
		result       = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ES_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ES_IDLE: begin
				if (up_valid) begin
					ray_q <= up_ray;
					vel_q <= up_ray.vel;
					pos_q <= up_ray.pos;
				end
			end
			ES_CLAMP: begin
				flag_q <= ray_q.flag | sat_hit(ray_q.acc[0]) | sat_hit(ray_q.acc[1])
				        | sat_hit(ray_q.acc[2]);
				for (int i = 0; i < 3; i++) begin
					accc_q[i] <= sat32(ray_q.acc[i]);
				end
				ax_q <= 2'd0;
			end
			ES_VEL_MUL, ES_POS_MUL: begin
				prod_q <= PRODW'(mul_mag) * PRODW'(time_step);
				neg_q  <= mul_src[DATA_W-1];
			end
			ES_VEL_ADD: begin
				vel_q[ax_q] <= sat32(sum);
				flag_q      <= flag_q | sat_hit(sum);
			end
			ES_POS_ADD: begin
				pos_q[ax_q] <= sat32(sum);
				flag_q      <= flag_q | sat_hit(sum);
				ax_q        <= ax_q + 2'd1;
			end
			ES_HOLD: begin
				if (load_out) begin
					out_q.new_pos_x <= pos_q[0];
					out_q.new_pos_y <= pos_q[1];
					out_q.new_pos_z <= pos_q[2];
					out_q.new_vel_x <= vel_q[0];
					out_q.new_vel_y <= vel_q[1];
					out_q.new_vel_z <= vel_q[2];
					out_q.accel_x   <= accc_q[0];
					out_q.accel_y   <= accc_q[1];
					out_q.accel_z   <= accc_q[2];
					out_q.saturated <= flag_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: test/grs_step_checker.sv
// Checker for the gravity ray Euler step unit: follows register writes, predicts
// each step result on sample acceptance and compares it with the result channel.
// Depends on grs_pkg.
`timescale 1ns / 1ps

module grs_step_checker import grs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  sample_valid,
	input  logic                  sample_ready,
	input  grs_in_t               sample,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  grs_out_t              result,
	output int                    pending,
	output int                    fails,
	output int                    results_seen
);

	localparam longint RANGE_LIM = longint'(1) << (DEF_FRAC_BITS + RANGE_BITS);
	localparam longint unsigned OVER_LIM = 64'd1 << QUOT_W;

	logic [HOLE_W-1:0] hole_word [NUM_HOLE_REGS];
	logic [COUNT_W-1:0] holes_used;
	logic [DT_W-1:0] dt_reg;
	grs_out_t step_queue [$];

	assign pending = step_queue.size();

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bit rescale_step(inout longint unsigned x, input longint unsigned d);
		longint unsigned q, r;
		q = x / d;
		r = x % d;
		if (q >= (64'd1 << (QUOT_W - DEF_FRAC_BITS))) return 1'b1;
		x = (q << DEF_FRAC_BITS) + ((r << DEF_FRAC_BITS) / d);
		return x >= OVER_LIM;
	endfunction

	function automatic longint clip32(input longint v, inout bit flag);
		if (v > longint'(32'sh7FFF_FFFF)) begin
			flag = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -longint'(64'h8000_0000)) begin
			flag = 1'b1;
			return -longint'(64'h8000_0000);
		end
		return v;
	endfunction

	function automatic longint scale_by_dt(input longint v);
		longint unsigned mag;
		longint r;
		mag = longint'(v < 0 ? -v : v) * longint'(dt_reg);
		r = longint'(mag >> DT_SHIFT);
		return v < 0 ? -r : r;
	endfunction

	function automatic void add_pull(input logic [HOLE_W-1:0] w, input longint pos [3],
			inout longint acc [3], inout bit flag);
		longint p [3];
		longint unsigned m [3];
		longint unsigned s, d, k, u, x;
		bit over;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			p[i] = pos[i] - longint'($signed(w[CENTER_W*i +: CENTER_W]))
				* (longint'(1) << (DEF_FRAC_BITS - CENTER_FRAC));
			m[i] = p[i] < 0 ? -p[i] : p[i];
			if (p[i] >= RANGE_LIM || p[i] <= -RANGE_LIM) return;
		end
		for (int i = 0; i < 3; i++) s += m[i] * m[i];
		if (s == 0) begin
			flag = 1'b1;
			return;
		end
		d = int_sqrt(s);
		k = longint'(w[HOLE_W-1 -: RADIUS_W]) * longint'(COEF_Q16);
		for (int i = 0; i < 3; i++) begin
			if (m[i] != 0) begin
				u = (m[i] << RECIP_SHIFT) / d;
				x = (k * u) >> (COEF_FRAC - DEF_FRAC_BITS);
				over = 1'b0;
				for (int n = 0; n < RESCALE_PASSES && !over; n++) over = rescale_step(x, d);
				if (over) begin
					flag = 1'b1;
					acc[i] += p[i] > 0 ? -longint'(64'h8000_0000) : longint'(32'sh7FFF_FFFF);
				end else begin
					acc[i] += p[i] > 0 ? -longint'(x >> RECIP_SHIFT) : longint'(x >> RECIP_SHIFT);
				end
			end
		end
	endfunction

	function automatic grs_out_t euler_step(input grs_in_t s);
		longint pos [3], vel [3], acc [3];
		int n;
		bit flag;
		grs_out_t r;
		flag = 1'b0;
		pos[0] = s.pos_x; pos[1] = s.pos_y; pos[2] = s.pos_z;
		vel[0] = s.vel_x; vel[1] = s.vel_y; vel[2] = s.vel_z;
		acc[0] = 0; acc[1] = 0; acc[2] = 0;
		n = holes_used > DEF_MAX_HOLES ? DEF_MAX_HOLES : int'(holes_used);
		for (int h = 0; h < n; h++) add_pull(hole_word[h], pos, acc, flag);
		for (int i = 0; i < 3; i++) begin
			acc[i] = clip32(acc[i], flag);
			vel[i] = clip32(vel[i] + scale_by_dt(acc[i]), flag);
			pos[i] = clip32(pos[i] + scale_by_dt(vel[i]), flag);
		end
		r.new_pos_x = pos[0][31:0]; r.new_pos_y = pos[1][31:0]; r.new_pos_z = pos[2][31:0];
		r.new_vel_x = vel[0][31:0]; r.new_vel_y = vel[1][31:0]; r.new_vel_z = vel[2][31:0];
		r.accel_x = acc[0][31:0]; r.accel_y = acc[1][31:0]; r.accel_z = acc[2][31:0];
		r.saturated = flag;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, $signed(want), $signed(got));
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grs_out_t want;
		logic [2:0] idx;
		if (!arst_n) begin
			for (int i = 0; i < NUM_HOLE_REGS; i++) hole_word[i] = '0;
			holes_used = '0;
			dt_reg = TIME_STEP_RESET;
			step_queue.delete();
			fails = 0;
			results_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				idx = paddr[5:3];
				case (idx)
					REG_HOLE_A, REG_HOLE_B, REG_HOLE_C, REG_HOLE_D: hole_word[idx[1:0]] = pwdata;
					REG_HOLE_COUNT: holes_used = pwdata[COUNT_W-1:0];
					REG_TIME_STEP: dt_reg = pwdata[DT_W-1:0];
					default: ;
				endcase
			end
			if (sample_valid && sample_ready) step_queue.push_back(euler_step(sample));
			if (result_valid && result_ready) begin
				results_seen++;
				if (step_queue.size() == 0) begin
					$error("result transaction with no step outstanding");
					fails++;
				end else begin
					want = step_queue.pop_front();
					check_field("new_pos_x", want.new_pos_x, result.new_pos_x);
					check_field("new_pos_y", want.new_pos_y, result.new_pos_y);
					check_field("new_pos_z", want.new_pos_z, result.new_pos_z);
					check_field("new_vel_x", want.new_vel_x, result.new_vel_x);
					check_field("new_vel_y", want.new_vel_y, result.new_vel_y);
					check_field("new_vel_z", want.new_vel_z, result.new_vel_z);
					check_field("accel_x", want.accel_x, result.accel_x);
					check_field("accel_y", want.accel_y, result.accel_y);
					check_field("accel_z", want.accel_z, result.accel_z);
					check_field("saturated", 32'(want.saturated), 32'(result.saturated));
				end
			end
		end
	end

endmodule

// File: test/testbench.sv
// Top of the gravity ray Euler step testbench: clock, reset, register phases,
// ray sample stimulus and the verdict. Depends on grs_pkg, grs_step_checker and
// gravity_ray_euler_step_unit.
`timescale 1ns / 1ps

module testbench import grs_pkg::*;;

	localparam int CYCLE_LIMIT = 30000000;
	localparam int DRAIN_WAIT = 4500;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 230;
	localparam logic [2:0] REG_UNUSED = 3'd6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_ready;
	grs_in_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	grs_out_t result;
	int pending, fails, results_seen;
	int cycles = 0;
	int idle_mode = 0;
	int sent = 0;
	logic [HOLE_W-1:0] cur_holes [NUM_HOLE_REGS];
	int cur_count = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	gravity_ray_euler_step_unit dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.sample_valid, .sample_ready, .sample, .result_valid, .result_ready, .result
	);

	grs_step_checker checker_i (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.sample_valid, .sample_ready, .sample, .result_valid, .result_ready, .result,
		.pending, .fails, .results_seen
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (idle_mode == 2) begin
			result_ready <= $urandom_range(0, 99) >= 72;
		end else if (idle_mode == 3) begin
			result_ready <= $urandom_range(0, 99) >= 7;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = {idx, 3'b000}; pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		if (idx < REG_HOLE_COUNT) cur_holes[idx[1:0]] = data;
		if (idx == REG_HOLE_COUNT) cur_count = data[COUNT_W-1:0];
	endtask

	task automatic wait_drained();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic send_ray(input grs_in_t s);
		int thresh;
		thresh = idle_mode == 1 ? 72 : (idle_mode == 3 ? 7 : 0);
		@(negedge clk);
		while ($urandom_range(0, 99) < thresh) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample = s;
		sample_valid = 1'b1;
		do @(posedge clk); while (!sample_ready);
		sent++;
	endtask

	function automatic logic [31:0] rand_width(input int w);
		logic [31:0] v;
		v = $urandom;
		if (w == 0) begin
			v = 32'd0;
		end else if (w < 32) begin
			v = 32'($signed(v << (32 - w)) >>> (32 - w));
		end
		return v;
	endfunction

	function automatic grs_in_t make_ray();
		grs_in_t s;
		longint c [3];
		int h;
		s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(0, 99) < 80 && cur_count != 0) begin
			h = $urandom_range(0, (cur_count > 4 ? 4 : cur_count) - 1);
			for (int i = 0; i < 3; i++)
				c[i] = longint'($signed(cur_holes[h][16*i +: 16])) * 4096;
			s.pos_x = 32'(c[0] + longint'($signed(rand_width($urandom_range(0, 28)))));
			s.pos_y = 32'(c[1] + longint'($signed(rand_width($urandom_range(0, 28)))));
			s.pos_z = 32'(c[2] + longint'($signed(rand_width($urandom_range(0, 28)))));
			s.vel_x = rand_width($urandom_range(0, 32));
			s.vel_y = rand_width($urandom_range(0, 32));
			s.vel_z = rand_width($urandom_range(0, 32));
		end
		return s;
	endfunction

	function automatic logic [HOLE_W-1:0] make_hole(input int kind);
		logic [HOLE_W-1:0] w;
		w = {$urandom, $urandom};
		if (kind == 1) w = {16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF};
		if (kind == 2) w[63:48] = 16'h0000;
		return w;
	endfunction

	initial begin
		grs_in_t s;
		logic [DT_W-1:0] dt;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a unit-radius hole at the origin and the unused register index.
		reg_write(REG_HOLE_A, {16'h0100, 48'h0});
		reg_write(REG_HOLE_COUNT, 64'd1);
		reg_write(REG_UNUSED, '1);
		s = '0;
		send_ray(s);
		s.pos_x = 32'sd1;
		send_ray(s);
		s = '0; s.pos_y = -32'sd1; s.pos_z = 32'sd1;
		send_ray(s);
		s = '0; s.pos_x = 32'sh0800_0000;
		send_ray(s);
		s.pos_x = 32'sh07FF_FFFF; s.pos_y = 32'sh07FF_FFFF;
		send_ray(s);
		s = '0; s.pos_z = 32'sh0010_0000;
		send_ray(s);
		s = {32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
		send_ray(s);
		s = {32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
		send_ray(s);
		s = '1;
		send_ray(s);
		s = '0; s.vel_x = 32'sh8000_0000; s.vel_y = 32'sh7FFF_FFFF;
		send_ray(s);
		s = '0; s.pos_x = 32'sd3; s.pos_y = -32'sd4;
		send_ray(s);
		sample_valid = 1'b0;
		wait_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			for (int i = 0; i < NUM_HOLE_REGS; i++)
				reg_write(grs_reg_t'(i), make_hole(ph == 1 ? 1 : (ph == 5 && i == 0 ? 2 : 0)));
			case (ph)
				0: reg_write(REG_HOLE_COUNT, 64'd0);
				1: reg_write(REG_HOLE_COUNT, 64'd4);
				2: reg_write(REG_HOLE_COUNT, 64'd7);
				default: reg_write(REG_HOLE_COUNT, 64'($urandom_range(1, 7)));
			endcase
			dt = ph == 0 ? 20'd0 : (ph == 1 ? 20'hFFFFF : 20'($urandom));
			if (ph == 4) dt = TIME_STEP_RESET;
			reg_write(REG_TIME_STEP, 64'(dt));
			idle_mode = ph % 4;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_ray(make_ray());
				if (ph == 3 && n == PHASE_ITEMS / 2) begin
					@(negedge clk);
					sample_valid = 1'b0;
					while (pending != 0) @(posedge clk);
				end
			end
			@(negedge clk);
			sample_valid = 1'b0;
			wait_drained();
		end

		idle_mode = 0;
		$display("Ran %0d ray samples over %0d register phases, %0d results checked.",
			sent, PHASES + 1, results_seen);
		$display("Hole counts 0 to 7, time steps 0 and full scale, all idle modes.");
		if (fails == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/grs_pkg.sv
design/grs_div.sv
design/grs_cell.sv
design/grs_euler.sv
design/gravity_ray_euler_step_unit.sv
test/grs_step_checker.sv
test/testbench.sv
